// File: design/fbpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and codes for the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

	// Field widths fixed by the interface
	localparam int ACTION_W  = 1;
	localparam int SIZE_W    = 16;
	localparam int SLOT_W    = 12;
	localparam int STATUS_W  = 2;
	localparam int OUTST_W   = 13;
	localparam int CFG_W     = 4;
	// Growth level register: holds up to the largest allowed cap
	localparam int LEVEL_W   = 5;

	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam action_t ACT_ALLOC = 1'b0;
	localparam action_t ACT_FREE  = 1'b1;

	localparam status_t STATUS_OK       = 2'd0;
	localparam status_t STATUS_FULL     = 2'd1;
	localparam status_t STATUS_SIZE     = 2'd2;
	localparam status_t STATUS_BAD_FREE = 2'd3;

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} fbpa_state_t;

endpackage

// File: design/fbpa_link_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_link_ram
// Single-write, single-read link memory with registered read data.
// ----------------------------------------------------------------------------
module fbpa_link_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 13
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: design/fixed_block_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block allocator: LIFO free list of slot numbers in a link RAM,
// backed by a lazily grown range of fresh slots.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction  Word
//  -------   ---------------------------------------   ---------  --------------
//  in        in_valid/in_ready, action, request_size,   in         one alloc/free
//            freed_slot
//  out       out_valid/out_ready, granted_slot,         out        one result
//            status, grew, outstanding
//  cfg       cfg_wr_en, cfg_wr_data                     in         growth level
//
//  A free, a failed allocate and an allocate served from the fresh range
//  leave the block in ST_IDLE. An allocate that pops the free list goes to
//  ST_POP, where the new list head arrives from the link RAM in the cycle after the read.
//  The result is registered at the accepting edge; a new word is taken while
//  a result waits, provided the consumer takes it in the same cycle.
//  Reset clears all control state; the link RAM needs no clearing pass, as an
//  entry is only read after it has been written.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
	import fbpa_pkg::*;
#(
	parameter int NUM_SLOTS       = 4096,
	parameter int MAX_LEVEL       = 12,
	parameter int MIN_BLOCK_BYTES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ACTION_W-1:0] action,
	input  logic [SIZE_W-1:0]   request_size,
	input  logic [SLOT_W-1:0]   freed_slot,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SLOT_W-1:0]   granted_slot,
	output logic [STATUS_W-1:0] status,
	output logic                grew,
	output logic [OUTST_W-1:0]  outstanding,
	// configuration
	input  logic                cfg_wr_en,
	input  logic [CFG_W-1:0]    cfg_wr_data
);

	// Slot index width, pointer width (pointer also holds the null marker)
	localparam int SW = $clog2(NUM_SLOTS);
	localparam int PW = SW + 1;
	// Common width for comparing and narrowing slot numbers
	localparam int CW = (PW > SLOT_W) ? PW : SLOT_W;
	// Width for the growth amount before it is clipped
	localparam int AW = (PW > MAX_LEVEL + 1) ? PW : MAX_LEVEL + 1;

	localparam logic [PW-1:0]      NULL_PTR  = PW'(NUM_SLOTS);
	localparam logic [SIZE_W-1:0]  MIN_SIZE  = SIZE_W'(MIN_BLOCK_BYTES);
	localparam logic [LEVEL_W-1:0] LEVEL_CAP = LEVEL_W'(MAX_LEVEL);

	fbpa_state_t state_q, state_d;

	// Pool state
	logic [PW-1:0]      free_head_q, free_head_d;
	logic [PW-1:0]      fresh_cursor_q, fresh_cursor_d;
	logic [PW-1:0]      fresh_end_q, fresh_end_d;
	logic [PW-1:0]      live_q, live_d;
	logic [LEVEL_W-1:0] level_q, level_d;
	logic [SIZE_W-1:0]  size_q, size_d;

	// Result register
	logic                out_valid_q, out_valid_d;
	logic [SLOT_W-1:0]   granted_q, granted_d;
	status_t             status_q, status_d;
	logic                grew_q, grew_d;
	logic [OUTST_W-1:0]  outst_q, outst_d;

	// Link RAM port
	logic                ram_wr_en, ram_rd_en;
	logic [PW-1:0]       ram_rd_data;

	logic                accept;
	logic [SIZE_W-1:0]   eff_size;
	logic                size_bad;
	logic                list_has;
	logic                need_grow;
	logic                pool_full;
	logic [LEVEL_W-1:0]  level_capped;
	logic [AW-1:0]       add_raw;
	logic [PW-1:0]       room;
	logic [PW-1:0]       add_clip;
	logic [CW-1:0]       freed_ext;
	logic [CW-1:0]       cursor_ext;
	logic [CW-1:0]       slot_pick;
	logic                free_bad;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	// Effective size, raised to the minimum block
	assign eff_size = (request_size < MIN_SIZE) ? MIN_SIZE : request_size;
	assign size_bad = (size_q != '0) && (size_q != eff_size);

	assign list_has  = free_head_q < NULL_PTR;
	assign need_grow = fresh_cursor_q >= fresh_end_q;
	assign pool_full = fresh_end_q >= NULL_PTR;

	// Growth amount: 2^min(level, cap), clipped to the room left
	assign level_capped = (level_q < LEVEL_CAP) ? level_q : LEVEL_CAP;
	assign add_raw      = AW'(1) << level_capped;
	assign room         = NULL_PTR - fresh_end_q;
	assign add_clip     = (add_raw > AW'(room)) ? room : add_raw[PW-1:0];

	// A free is bad when the slot was never handed out or nothing is live
	assign freed_ext  = CW'(freed_slot);
	assign cursor_ext = CW'(fresh_cursor_q);
	assign free_bad   = (freed_ext >= cursor_ext) || (live_q == '0);

	assign ram_rd_en = accept && (action == ACT_ALLOC) && !size_bad && list_has;
	assign ram_wr_en = accept && (action == ACT_FREE) && !free_bad;

	fbpa_link_ram #(
		.DEPTH (NUM_SLOTS),
		.WIDTH (PW)
	) u_link_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (freed_ext[SW-1:0]),
		.wr_data (free_head_q),
		.rd_en   (ram_rd_en),
		.rd_addr (free_head_q[SW-1:0]),
		.rd_data (ram_rd_data)
	);

	// Next state, pool update and result
	always_comb begin
		state_d        = state_q;
		free_head_d    = free_head_q;
		fresh_cursor_d = fresh_cursor_q;
		fresh_end_d    = fresh_end_q;
		live_d         = live_q;
		level_d        = level_q;
		size_d         = size_q;
		out_valid_d    = out_valid_q && !out_ready;
		granted_d      = granted_q;
		status_d       = status_q;
		grew_d         = grew_q;
		outst_d        = outst_q;
		slot_pick      = '0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					out_valid_d = 1'b1;
					granted_d   = '0;
					grew_d      = 1'b0;
					status_d    = STATUS_OK;
					if (action == ACT_ALLOC) begin
						if (size_bad) begin
							status_d = STATUS_SIZE;
						end else if (list_has) begin
							// Pop: the new head arrives from the link RAM next cycle
							slot_pick = CW'(free_head_q);
							live_d    = live_q + 1'b1;
							state_d   = ST_POP;
						end else if (!need_grow) begin
							slot_pick      = CW'(fresh_cursor_q);
							fresh_cursor_d = fresh_cursor_q + 1'b1;
							live_d         = live_q + 1'b1;
						end else if (pool_full) begin
							status_d = STATUS_FULL;
						end else begin
							// Grow the pool and hand out the first new slot
							slot_pick      = CW'(fresh_end_q);
							fresh_cursor_d = fresh_end_q + 1'b1;
							fresh_end_d    = fresh_end_q + add_clip;
							live_d         = live_q + 1'b1;
							grew_d         = 1'b1;
							if (level_q < LEVEL_CAP) begin
								level_d = level_q + 1'b1;
							end
						end
						if ((status_d == STATUS_OK) && (size_q == '0)) begin
							size_d = eff_size;
						end
					end else begin
						if (free_bad) begin
							status_d = STATUS_BAD_FREE;
						end else begin
							// Push: old head was written into the slot's link
							free_head_d = freed_ext[PW-1:0];
							live_d      = live_q - 1'b1;
						end
					end
					granted_d = slot_pick[SLOT_W-1:0];
					outst_d   = OUTST_W'(live_d);
				end
			end
			ST_POP: begin
				free_head_d = ram_rd_data;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q    <= NULL_PTR;
			fresh_cursor_q <= '0;
			fresh_end_q    <= '0;
			live_q         <= '0;
			size_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			free_head_q    <= free_head_d;
			fresh_cursor_q <= fresh_cursor_d;
			fresh_end_q    <= fresh_end_d;
			live_q         <= live_d;
			size_q         <= size_d;
			out_valid_q    <= out_valid_d;
		end
	end

	// Growth level: a configuration write reloads it until the first growth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_W'(4);
		end else if (cfg_wr_en) begin
			if (fresh_end_q == '0) begin
				level_q <= LEVEL_W'(cfg_wr_data);
			end
		end else begin
			level_q <= level_d;
		end
	end

	// Result payload holds while the word waits
	always_ff @(posedge clk) begin
		granted_q <= granted_d;
		status_q  <= status_d;
		grew_q    <= grew_d;
		outst_q   <= outst_d;
	end

	assign out_valid    = out_valid_q;
	assign granted_slot = granted_q;
	assign status       = status_q;
	assign grew         = grew_q;
	assign outstanding  = outst_q;

endmodule

// File: tb/fbpa_slot_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_slot_checker
// Watches the request and result channels of the block pool allocator, works
// out the result of every accepted word from its own copy of the pool state
// and compares each returned result with the oldest one still due.
// ----------------------------------------------------------------------------
module fbpa_slot_checker
	import fbpa_pkg::*;
#(
	parameter int NUM_SLOTS       = 4096,
	parameter int MAX_LEVEL       = 12,
	parameter int MIN_BLOCK_BYTES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  action_t             action,
	input  logic [SIZE_W-1:0]   request_size,
	input  logic [SLOT_W-1:0]   freed_slot,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [SLOT_W-1:0]   granted_slot,
	input  status_t             status,
	input  logic                grew,
	input  logic [OUTST_W-1:0]  outstanding,
	input  logic                cfg_wr_en,
	input  logic [CFG_W-1:0]    cfg_wr_data,
	output int                  fail_count,
	output int                  results_due
);

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		status_t            code;
		logic               grown;
		logic [OUTST_W-1:0] live;
	} grant_t;

	// 13-bit links so that the empty-list marker fits
	logic [OUTST_W-1:0] link_ram [NUM_SLOTS];
	int unsigned        list_head;
	int unsigned        fresh_next;
	int unsigned        fresh_limit;
	int unsigned        level;
	int unsigned        latched_bytes;
	int unsigned        live_blocks;
	grant_t             due_grants[$];
	grant_t             got;
	grant_t             want;
	int                 mismatches = 0;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Advance the pool by one word and return the result it must give.
	function automatic grant_t grant_for_word(input action_t kind,
			input logic [SIZE_W-1:0] size, input logic [SLOT_W-1:0] slot);
		grant_t      r;
		int unsigned eff;
		int unsigned add;
		int unsigned take;
		r = '0;
		take = 0;
		if (kind == ACT_ALLOC) begin
			eff = (size < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : size;
			if (latched_bytes != 0 && latched_bytes != eff) begin
				r.code = STATUS_SIZE;
			end else if (list_head >= NUM_SLOTS && fresh_next >= fresh_limit
					&& fresh_limit >= NUM_SLOTS) begin
				r.code = STATUS_FULL;
			end else begin
				if (list_head < NUM_SLOTS) begin
					take = list_head;
					list_head = link_ram[take];
				end else begin
					if (fresh_next >= fresh_limit) begin
						add = 1 << ((level < MAX_LEVEL) ? level : MAX_LEVEL);
						if (add > NUM_SLOTS - fresh_limit)
							add = NUM_SLOTS - fresh_limit;
						fresh_next = fresh_limit;
						fresh_limit += add;
						if (level < MAX_LEVEL)
							level++;
						r.grown = 1'b1;
					end
					take = fresh_next;
					fresh_next++;
				end
				if (latched_bytes == 0)
					latched_bytes = eff;
				live_blocks++;
				r.slot = take[SLOT_W-1:0];
			end
		end else begin
			if (slot >= fresh_next || live_blocks == 0) begin
				r.code = STATUS_BAD_FREE;
			end else begin
				link_ram[slot] = list_head[OUTST_W-1:0];
				list_head = slot;
				live_blocks--;
			end
		end
		r.live = live_blocks[OUTST_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_head     = NUM_SLOTS;
			fresh_next    = 0;
			fresh_limit   = 0;
			level         = 4;
			latched_bytes = 0;
			live_blocks   = 0;
			due_grants.delete();
			results_due <= 0;
			fail_count  <= mismatches;
		end else begin
			// the growth level only follows the register until the first growth
			if (cfg_wr_en) begin
				if (fresh_limit == 0)
					level = cfg_wr_data;
			end
			if (out_valid && out_ready) begin
				got = '{granted_slot, status, grew, outstanding};
				if (due_grants.size() == 0) begin
					report_mismatch($sformatf("result with nothing due: slot %0d status %0d",
						granted_slot, status));
				end else begin
					want = due_grants.pop_front();
					if (got.slot !== want.slot)
						report_mismatch($sformatf("granted_slot %0d, expected %0d",
							got.slot, want.slot));
					if (got.code !== want.code)
						report_mismatch($sformatf("status %0d, expected %0d",
							got.code, want.code));
					if (got.grown !== want.grown)
						report_mismatch($sformatf("grew %0d, expected %0d",
							got.grown, want.grown));
					if (got.live !== want.live)
						report_mismatch($sformatf("outstanding %0d, expected %0d",
							got.live, want.live));
				end
			end
			if (in_valid && in_ready)
				due_grants.push_back(grant_for_word(action, request_size, freed_slot));
			results_due <= due_grants.size();
			fail_count  <= mismatches;
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives alloc and free words into the block pool allocator with random gaps
// on both channels: a directed opening, three random phases, each after a
// growth-level write that the block ignores once the pool has grown, then a
// short run of returns and allocations. The checker beside the block predicts
// and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import fbpa_pkg::*;

	// cycles with no word moving on either channel before giving up
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_WORDS = 225;
	// sizes up to this all round up to the latched block size
	localparam int BLOCK_BYTES = 8;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_ready;
	action_t             action       = ACT_ALLOC;
	logic [SIZE_W-1:0]   request_size = '0;
	logic [SLOT_W-1:0]   freed_slot   = '0;
	logic                out_valid;
	logic                out_ready    = 1'b0;
	logic [SLOT_W-1:0]   granted_slot;
	logic [STATUS_W-1:0] status;
	logic                grew;
	logic [OUTST_W-1:0]  outstanding;
	logic                cfg_wr_en    = 1'b0;
	logic [CFG_W-1:0]    cfg_wr_data  = '0;

	int                  fail_count;
	int                  results_due;
	// no idling on either side while this is set
	logic                calm         = 1'b0;
	int                  stall_cycles = 0;
	// slots handed out and not yet returned, as seen on the result channel
	logic [SLOT_W-1:0]   held_slots[$];
	action_t             sent_kinds[$];
	action_t             done_kind;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	fixed_block_pool_allocator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.request_size (request_size),
		.freed_slot   (freed_slot),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.granted_slot (granted_slot),
		.status       (status),
		.grew         (grew),
		.outstanding  (outstanding),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	fbpa_slot_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.request_size (request_size),
		.freed_slot   (freed_slot),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.granted_slot (granted_slot),
		.status       (status),
		.grew         (grew),
		.outstanding  (outstanding),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.fail_count   (fail_count),
		.results_due  (results_due)
	);

	// Stall the result side about a third of the time, except while calm.
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 34);
	end

	// Track granted slots for the free stimulus. Sample at the falling edge:
	// every signal here moves only at the rising edge, so a handshake seen now
	// is the one taken at the next rising edge, and the stimulus process can
	// read the lists at that edge without racing this block.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sent_kinds.push_back(action);
			if (out_valid && out_ready && sent_kinds.size() != 0) begin
				done_kind = sent_kinds.pop_front();
				if (done_kind == ACT_ALLOC && status == STATUS_OK)
					held_slots.push_back(granted_slot);
			end
		end
	end

	// Watchdog: count cycles in which no word moves, reset on any handshake.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("** fixed_block_pool_allocator: FAILED **");
			$finish;
		end
	end

	// Present one word and hold it until taken. Return in the step of the
	// accepting edge, so the caller either follows with the next word or drops
	// valid in that same step.
	task automatic send_word(input action_t kind, input logic [SIZE_W-1:0] size,
			input logic [SLOT_W-1:0] slot);
		while (!calm && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= kind;
		request_size <= size;
		freed_slot   <= slot;
		do @(posedge clk); while (!in_ready);
	endtask

	// The unused field of each word carries random bits.
	task automatic alloc_word(input logic [SIZE_W-1:0] size);
		send_word(ACT_ALLOC, size, SLOT_W'($urandom));
	endtask

	task automatic free_word(input logic [SLOT_W-1:0] slot);
		send_word(ACT_FREE, SIZE_W'($urandom), slot);
	endtask

	// Return one slot that is known to be live; fall back to noise if none is.
	task automatic free_held();
		int                idx;
		logic [SLOT_W-1:0] s;
		if (held_slots.size() == 0) begin
			free_word(SLOT_W'($urandom));
		end else begin
			idx = $urandom_range(held_slots.size() - 1);
			s = held_slots[idx];
			held_slots.delete(idx);
			free_word(s);
		end
	endtask

	// Mostly well-formed traffic: allocations of the latched size and frees of
	// live slots. The rest is size mismatches and frees of random slots, which
	// are nearly always slots never handed out.
	task automatic random_word();
		int                pick;
		int                hit[$];
		logic [SLOT_W-1:0] s;
		pick = $urandom_range(99);
		if (pick < 58) begin
			alloc_word(SIZE_W'($urandom_range(1, BLOCK_BYTES)));
		end else if (pick < 63) begin
			alloc_word(SIZE_W'($urandom_range(1, 65535)));
		end else if (pick < 93) begin
			free_held();
		end else begin
			s = SLOT_W'($urandom);
			// drop a live slot from the list if hit, so it is not returned twice
			hit = held_slots.find_first_index(x) with (x == s);
			if (hit.size() != 0)
				held_slots.delete(hit[0]);
			free_word(s);
		end
	endtask

	// Drop valid and wait until every result due has come back.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
	endtask

	// Write the growth level register; only while nothing is in flight.
	task automatic write_level(input logic [CFG_W-1:0] lvl);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= lvl;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [SLOT_W-1:0] twice;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Before the first growth a write also loads the growth level: leave it
		// at zero so the pool grows by 1, 2, 4 and so on, doubling up to the cap.
		write_level(4'd15);
		write_level(4'd0);

		// Directed opening
		free_word('0);                  // nothing handed out and nothing live
		free_word('1);
		alloc_word(16'd3);              // below the floor: latches 8, grows by one
		alloc_word(16'd8);              // grows again
		alloc_word(16'd1);
		alloc_word(16'hFFFF);           // size mismatch
		alloc_word(16'd9);              // one above the latched size
		free_word(12'd2);
		free_word(12'd1);
		alloc_word(16'd8);              // pop the free list
		alloc_word(16'd8);              // pop again, back to back
		alloc_word(16'd8);              // list empty and fresh range used up
		free_word('1);                  // never handed out
		free_word(12'd4);               // exactly at the fresh cursor
		free_word(12'd3);
		free_word(12'd0);
		alloc_word(16'd5);
		alloc_word(16'd2);
		free_word(12'd0);
		free_word(12'd1);
		free_word(12'd2);
		free_word(12'd3);
		free_word(12'd1);               // handed out before, but nothing is live
		settle();
		held_slots.delete();

		// Random phases; the middle one runs with no idling at all.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0:       write_level(4'd12);
				1:       write_level(CFG_W'($urandom_range(0, 12)));
				default: write_level(4'd0);
			endcase
			calm <= (phase == 1);
			repeat (PHASE_WORDS) random_word();
			settle();
		end

		// Return some slots, then allocate again.
		calm <= 1'b0;
		write_level(CFG_W'($urandom_range(0, 12)));
		repeat (24) free_held();
		repeat (30) alloc_word(SIZE_W'($urandom_range(1, BLOCK_BYTES)));
		settle();

		// Return one live slot twice while others are live: it goes on the list
		// twice. Keep this last, as the list loops from here on.
		twice = held_slots[$urandom_range(held_slots.size() - 1)];
		free_word(twice);
		free_word(twice);
		repeat (4) alloc_word(SIZE_W'($urandom_range(1, BLOCK_BYTES)));
		settle();
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("** fixed_block_pool_allocator: PASSED **");
		else
			$display("** fixed_block_pool_allocator: FAILED **");
		$finish;
	end

endmodule
